FILE: hw/rtl/brbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brbf_pkg: shared types and constants
// Actions, controller states and the command/status structs between the
// controller and the datapath of the bucketed range bitmap filter.
// ----------------------------------------------------------------------------
package brbf_pkg;

	localparam int Words     = 1024;
	localparam int LogBits   = 6;
	localparam int WordAw    = $clog2(Words);
	localparam int BucketW   = WordAw + LogBits;
	localparam int CountW    = 17;
	localparam logic [CountW-1:0] CountMax = '1;
	localparam int KeyW      = 64;

	typedef enum logic [2:0] {
		ACT_CLEAR  = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_PROBE  = 3'd2,
		ACT_RANGE  = 3'd3,
		ACT_COUNT  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		REG_MIN_KEY  = 2'd0,
		REG_KEY_SPAN = 2'd1,
		REG_SHIFT    = 2'd2,
		REG_SIGNED   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_PREP,
		ST_RD,
		ST_CHK,
		ST_WR,
		ST_CLEAR,
		ST_RQ1,
		ST_RQ2,
		ST_SCAN,
		ST_SCHK,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture input item
		logic prep;        // compute offsets and buckets
		logic rd_item;     // read word of item bucket
		logic ins_wr;      // write set bit back
		logic clr_wr;      // clear word at sweep address
		logic clr_start;   // reset sweep address and counter
		logic rq1;         // range: bounds checks
		logic rq2;         // range: clamp and bucket numbers
		logic scan_rd;     // read scan word
		logic scan_next;   // advance scan address
		logic res_probe;   // latch probe result
		logic res_range;   // latch range hit from scan word
		logic res_set;     // force match to a given value
		logic res_val;
		logic res_zero;    // match 0
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		action_t action;
		logic    item_ok;   // key in span and capacity
		logic    bit_set;   // read bit of item
		logic    clr_last;
		logic    rq_early;  // range answered before scan
		logic    rq_early_val;
		logic    rq2_early;
		logic    rq2_early_val;
		logic    scan_hit;
		logic    scan_last;
	} status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/brbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brbf_ctrl: controller
// Sequences memory clear, insert, probe, range scan and count; drives the handshake.
// ----------------------------------------------------------------------------
module brbf_ctrl import brbf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire status_t st,
	output cmd_t         cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				case (st.action) inside
					ACT_CLEAR: begin
						cmd.clr_start = 1'b1;
						state_d       = ST_CLEAR;
					end
					ACT_INSERT, ACT_PROBE: state_d = ST_RD;
					ACT_RANGE: state_d = ST_RQ1;
					default: begin
						cmd.res_zero = 1'b1;
						state_d      = ST_OUT;
					end
				endcase
			end
			ST_RD: begin
				cmd.rd_item = 1'b1;
				state_d     = ST_CHK;
			end
			ST_CHK: begin
				if (st.action == ACT_PROBE) begin
					cmd.res_probe = 1'b1;
					state_d       = ST_OUT;
				end else begin
					cmd.res_zero = 1'b1;
					state_d      = (st.item_ok && !st.bit_set) ? ST_WR : ST_OUT;
				end
			end
			ST_WR: begin
				cmd.ins_wr = 1'b1;
				state_d    = ST_OUT;
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					cmd.res_zero = 1'b1;
					state_d      = ST_OUT;
				end
			end
			ST_RQ1: begin
				cmd.rq1 = 1'b1;
				state_d = ST_RQ2;
			end
			ST_RQ2: begin
				if (st.rq_early) begin
					cmd.res_set = 1'b1;
					cmd.res_val = st.rq_early_val;
					state_d     = ST_OUT;
				end else begin
					cmd.rq2 = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.rq2_early) begin
					cmd.res_set = 1'b1;
					cmd.res_val = st.rq2_early_val;
					state_d     = ST_OUT;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = ST_SCHK;
				end
			end
			ST_SCHK: begin
				cmd.res_range = 1'b1;
				if (st.scan_hit || st.scan_last) begin
					state_d = ST_OUT;
				end else begin
					cmd.scan_next = 1'b1;
					cmd.scan_rd   = 1'b1;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	ap_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> state_q == ST_IDLE)
		else $error("result taken but controller not idle");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");
	ap_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_stall == 1'b0 && out_valid))
		else $error("input taken while result pending");

endmodule
`default_nettype wire

FILE: hw/rtl/brbf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brbf_dp: datapath
// Configuration registers, bitmap memory, bucket arithmetic, scan and counter.
// ----------------------------------------------------------------------------
module brbf_dp import brbf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [KeyW-1:0]   cfg_data,
	input  wire logic [2:0]        action,
	input  wire logic [KeyW-1:0]   key,
	input  wire logic [KeyW-1:0]   upper_key,
	input  wire cmd_t              cmd,
	output status_t                st,
	output logic                   match,
	output logic [CountW-1:0]      active_count
);

	logic [KeyW-1:0] min_q, span_q;
	logic [5:0]      shift_q;
	logic            sgn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			span_q  <= '0;
			shift_q <= '0;
			sgn_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MIN_KEY:  min_q   <= cfg_data;
				REG_KEY_SPAN: span_q  <= cfg_data;
				REG_SHIFT:    shift_q <= cfg_data[5:0];
				REG_SIGNED:   sgn_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	function automatic logic kless(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b,
			input logic s);
		logic [KeyW-1:0] x, y;
		x = a ^ {s, {(KeyW-1){1'b0}}};
		y = b ^ {s, {(KeyW-1){1'b0}}};
		return x < y;
	endfunction

	action_t         act_q;
	logic [KeyW-1:0] lo_q, hi_q, top_q;
	logic            item_ok_q;
	logic [BucketW-1:0] bkt_q, ub_q;
	logic [KeyW-1:0] off;
	logic [KeyW-1:0] bsh;

	assign off = lo_q - min_q;
	assign bsh = off >> shift_q;

	// memory
	logic [KeyW-1:0] mem [Words];
	logic [KeyW-1:0] rdata_q;
	logic [WordAw-1:0] rd_addr, clr_addr_q, scan_q, uw_q;
	logic [WordAw-1:0] lw;
	logic [LogBits-1:0] lbit_q;
	logic             rd_en;

	assign lw    = bkt_q[BucketW-1:LogBits];
	assign rd_en = cmd.rd_item || cmd.scan_rd;
	assign rd_addr = cmd.rd_item ? lw : (cmd.scan_next ? scan_q + 1'b1 : scan_q);

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.ins_wr) begin
			mem[lw] <= rdata_q | (KeyW'(1) << bkt_q[LogBits-1:0]);
		end
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	logic rq_early_q, rq_early_val_q, rq2_early_q, rq2_early_val_q;
	logic [KeyW-1:0] mask;
	logic [CountW-1:0] cnt_q;
	logic match_q;
	logic bs_hi;

	// bucket offset above capacity?
	assign bs_hi = |bsh[KeyW-1:BucketW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (cmd.clr_start) begin
				clr_addr_q <= '0;
				cnt_q      <= '0;
			end else if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.ins_wr && cnt_q != CountMax) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action_t'(action);
			lo_q  <= key;
			hi_q  <= upper_key;
		end
		if (cmd.prep) begin
			top_q     <= min_q + span_q;
			item_ok_q <= !(off > span_q) && !bs_hi;
			bkt_q     <= bsh[BucketW-1:0];
		end
		if (cmd.rq1) begin
			rq_early_q     <= 1'b1;
			rq_early_val_q <= 1'b0;
			if (kless(hi_q, lo_q, sgn_q)) begin
				rq_early_val_q <= 1'b1;
			end else if (kless(hi_q, min_q, sgn_q) || kless(top_q, lo_q, sgn_q)) begin
				rq_early_val_q <= 1'b0;
			end else begin
				rq_early_q <= 1'b0;
				if (kless(lo_q, min_q, sgn_q)) lo_q <= min_q;
				if (kless(top_q, hi_q, sgn_q)) hi_q <= top_q;
			end
		end
		if (cmd.rq2) begin
			logic [KeyW-1:0] lbs, ubs;
			lbs = (lo_q - min_q) >> shift_q;
			ubs = (hi_q - min_q) >> shift_q;
			rq2_early_q     <= 1'b0;
			rq2_early_val_q <= 1'b0;
			if (kless(hi_q, lo_q, sgn_q)) begin
				rq2_early_q     <= 1'b1;
				rq2_early_val_q <= 1'b1;
			end else if (|lbs[KeyW-1:BucketW]) begin
				rq2_early_q <= 1'b1;
			end
			bkt_q  <= lbs[BucketW-1:0];
			scan_q <= lbs[BucketW-1:LogBits];
			lbit_q <= lbs[LogBits-1:0];
			ub_q   <= (|ubs[KeyW-1:BucketW]) ? '1 : ubs[BucketW-1:0];
			uw_q   <= (|ubs[KeyW-1:BucketW]) ? '1 : ubs[BucketW-1:LogBits];
		end
		if (cmd.scan_next) scan_q <= scan_q + 1'b1;
		if (cmd.res_zero)  match_q <= 1'b0;
		if (cmd.res_set)   match_q <= cmd.res_val;
		if (cmd.res_probe) match_q <= item_ok_q & rdata_q[bkt_q[LogBits-1:0]];
		if (cmd.res_range) match_q <= |(rdata_q & mask);
	end

	always_comb begin
		mask = '1;
		if (scan_q == lw) mask = mask & ('1 << lbit_q);
		if (scan_q == uw_q) mask = mask & ('1 >> (6'd63 - ub_q[LogBits-1:0]));
	end

	always_comb begin
		st               = '0;
		st.action        = act_q;
		st.item_ok       = item_ok_q;
		st.bit_set       = rdata_q[bkt_q[LogBits-1:0]];
		st.clr_last      = &clr_addr_q;
		st.rq_early      = rq_early_q;
		st.rq_early_val  = rq_early_val_q;
		st.rq2_early     = rq2_early_q;
		st.rq2_early_val = rq2_early_val_q;
		st.scan_hit      = |(rdata_q & mask);
		st.scan_last     = scan_q == uw_q;
	end

	assign match        = match_q;
	assign active_count = cnt_q;

	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_start |=> cnt_q == '0)
		else $error("count not cleared");
	ap_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ins_wr && !cmd.clr_start |=> cnt_q == $past(cnt_q))
		else $error("count moved without insert");
	ap_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_wr && cmd.ins_wr))
		else $error("two memory writes");

endmodule
`default_nettype wire

FILE: hw/rtl/bucketed_range_bitmap_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Probe/insert read the bitmap word of the item's bucket; count needs no memory access.
// A range query scans bitmap words (up to 1024) until a hit or the upper word, unless
// the bounds alone decide. Clear sweeps 1024 words, one a cycle.
// One item in flight; the next item can be taken in the cycle after the result leaves.
// After reset a clearing pass runs over all 1024 words; no item is taken meanwhile.
// ----------------------------------------------------------------------------
// bucketed_range_bitmap_filter: top level
// Bucketed membership bitmap with insert, probe, range query and count.
// ----------------------------------------------------------------------------
module bucketed_range_bitmap_filter import brbf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [KeyW-1:0]   cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        action,
	input  wire logic [KeyW-1:0]   key,
	input  wire logic [KeyW-1:0]   upper_key,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   match,
	output logic [CountW-1:0]      active_count
);

	cmd_t    cmd;
	status_t st;

	brbf_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .st, .cmd
	);

	brbf_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .action, .key, .upper_key,
		.cmd, .st, .match, .active_count
	);

endmodule
`default_nettype wire
